>>> rtl/core/itaf_pkg.sv
// Package for the integer-to-ASCII formatter: widths, codes, job and
// control structs, state types and the digit character function.
// No dependencies; every other file of the block depends on it.
package itaf_pkg;

    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 6;
    localparam int WIDTH_W  = 6;
    localparam int FLAG_W   = 5;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    // Output cap in characters.
    localparam int MAX_CHARS = 64;

    // One digit cell per value bit covers base 2.
    localparam int NDIG       = VALUE_W;
    localparam int DIG_W      = RADIX_W;
    localparam int BIT_W      = $clog2(VALUE_W);
    localparam int CNT_W      = 7;
    localparam int ALIGN_STEP = 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Flag bit positions.
    localparam int FL_ZERO   = 0;
    localparam int FL_LEFT   = 1;
    localparam int FL_SPACE  = 2;
    localparam int FL_SIGNED = 3;
    localparam int FL_PREFIX = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    localparam logic [1:0] PRE_LEN_NONE = 2'd0;
    localparam logic [1:0] PRE_LEN_OCT  = 2'd1;
    localparam logic [1:0] PRE_LEN_HEX  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADBASE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

    typedef struct packed {
        logic               err;
        logic               has_sign;
        logic               minus;
        logic [1:0]         pre_len;
        logic               zero;
        logic               left;
        logic [VALUE_W-1:0] mag;
        logic [RADIX_W-1:0] radix;
        logic [WIDTH_W-1:0] fw;
        logic [WIDTH_W-1:0] prec;
    } t_job;

    typedef struct packed {
        logic start;
        logic pop;
    } t_conv_ctl;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] nd;
    } t_conv_sts;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_ALIGN,
        CV_DONE
    } t_conv_state;

    typedef enum logic [3:0] {
        EM_IDLE,
        EM_WAIT,
        EM_ERROR,
        EM_PREFIX,
        EM_LSPACE,
        EM_SIGN,
        EM_ZFILL,
        EM_PZERO,
        EM_DIGIT,
        EM_TSPACE
    } t_emit_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIG_W'(10)) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_UPPER_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/itaf_if.sv
// Valid/ready channel interfaces of the formatter: request and character.
// Depends on itaf_pkg for the field widths.
interface itaf_in_if;
    logic                            valid;
    logic                            ready;
    logic [itaf_pkg::VALUE_W-1:0]    value;
    logic [itaf_pkg::RADIX_W-1:0]    radix;
    logic [itaf_pkg::WIDTH_W-1:0]    field_width;
    logic [itaf_pkg::WIDTH_W-1:0]    min_digits;
    logic [itaf_pkg::FLAG_W-1:0]     flag_bits;

    modport source (output valid, value, radix, field_width, min_digits, flag_bits,
                    input ready);
    modport sink (input valid, value, radix, field_width, min_digits, flag_bits,
                  output ready);
endinterface

interface itaf_out_if;
    logic                            valid;
    logic                            ready;
    logic [itaf_pkg::CHAR_W-1:0]     ch;
    logic                            last;
    logic [itaf_pkg::STATUS_W-1:0]   status;

    modport source (output valid, ch, last, status, input ready);
    modport sink (input valid, ch, last, status, output ready);
endinterface

>>> rtl/core/itaf_front.sv
// Front end: accepts a request, checks the base, takes the magnitude and
// sign, resolves the flags and pushes one job into the queue.
// Depends on itaf_pkg and itaf_if.
module itaf_front (
    itaf_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output itaf_pkg::t_job o_job
);
    import itaf_pkg::*;

    logic w_neg;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign w_neg = i_in.flag_bits[FL_SIGNED] && i_in.value[VALUE_W-1];

    always_comb begin
        o_job.err      = (i_in.radix < RADIX_MIN) || (i_in.radix > RADIX_MAX);
        o_job.minus    = w_neg;
        o_job.has_sign = w_neg || (i_in.flag_bits[FL_SIGNED] && i_in.flag_bits[FL_SPACE]);
        o_job.left     = i_in.flag_bits[FL_LEFT];
        // Left alignment cancels zero fill.
        o_job.zero     = i_in.flag_bits[FL_ZERO] && !i_in.flag_bits[FL_LEFT];
        o_job.mag      = w_neg ? (~i_in.value) + VALUE_W'(1) : i_in.value;
        o_job.radix    = i_in.radix;
        o_job.fw       = i_in.field_width;
        o_job.prec     = i_in.min_digits;
        if (!i_in.flag_bits[FL_PREFIX]) begin
            o_job.pre_len = PRE_LEN_NONE;
        end else if (i_in.radix == RADIX_HEX) begin
            o_job.pre_len = PRE_LEN_HEX;
        end else if (i_in.radix == RADIX_OCT) begin
            o_job.pre_len = PRE_LEN_OCT;
        end else begin
            o_job.pre_len = PRE_LEN_NONE;
        end
    end

endmodule

>>> rtl/core/itaf_fifo.sv
// Two-entry job queue between the front end and the back end.
// Depends on itaf_pkg for the job struct and the depth.
module itaf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itaf_pkg::t_job i_din,
    output logic           o_full,
    input  logic           i_pop,
    output itaf_pkg::t_job o_dout,
    output logic           o_empty
);
    import itaf_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

    assign o_dout  = r_mem[r_rd];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

>>> rtl/core/itaf_conv.sv
// Digit converter: a row of base-b digit cells that doubles and adds one
// magnitude bit per cycle, then shifts the top digit to the last cell.
// Depends on itaf_pkg.
module itaf_conv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itaf_pkg::t_conv_ctl          i_ctl,
    input  logic [itaf_pkg::VALUE_W-1:0] i_mag,
    input  logic [itaf_pkg::RADIX_W-1:0] i_radix,
    output itaf_pkg::t_conv_sts          o_sts,
    output logic [itaf_pkg::DIG_W-1:0]   o_top_digit
);
    import itaf_pkg::*;

    t_conv_state        r_state;
    t_conv_state        n_state;
    logic [DIG_W-1:0]   r_dig [NDIG];
    logic [VALUE_W-1:0] r_mag;
    logic [DIG_W-1:0]   r_base;
    logic [BIT_W-1:0]   r_bit;
    logic [CNT_W-1:0]   r_nd;
    logic [CNT_W-1:0]   r_rem;

    logic [NDIG-1:0]    w_gen;
    logic [NDIG-1:0]    w_prop;
    logic [NDIG:0]      w_sum;
    logic [NDIG:0]      w_carry;
    logic [DIG_W-1:0]   w_next [NDIG];
    logic [CNT_W-1:0]   w_nd_new;

    // A cell generates a carry when twice its digit reaches the base, and
    // passes one through when twice its digit is one below the base. The
    // carry chain is then the carry vector of one wide add.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_gen[i]  = ({r_dig[i], 1'b0} >= {1'b0, r_base});
            w_prop[i] = ({r_dig[i], 1'b1} == {1'b0, r_base});
        end
        w_sum = {1'b0, w_gen | w_prop} + {1'b0, w_gen} + {{NDIG{1'b0}}, r_mag[VALUE_W-1]};
        w_carry[0] = r_mag[VALUE_W-1];
        for (int i = 1; i < NDIG; i++) begin
            w_carry[i] = w_sum[i] ^ w_prop[i];
        end
        w_carry[NDIG] = w_sum[NDIG];
        for (int i = 0; i < NDIG; i++) begin
            if (w_carry[i+1]) begin
                w_next[i] = DIG_W'({r_dig[i], w_carry[i]} - {1'b0, r_base});
            end else begin
                w_next[i] = {r_dig[i][DIG_W-2:0], w_carry[i]};
            end
        end
        w_nd_new = r_nd + CNT_W'(w_carry[r_nd]);
    end

    always_comb begin
        n_state = r_state;
        if (i_ctl.start) begin
            n_state = CV_RUN;
        end else begin
            case (r_state)
                CV_IDLE:  n_state = CV_IDLE;
                CV_RUN: begin
                    if (r_bit == '0) begin
                        n_state = CV_ALIGN;
                    end
                end
                CV_ALIGN: begin
                    if (r_rem == '0) begin
                        n_state = CV_DONE;
                    end
                end
                CV_DONE:  n_state = CV_DONE;
                default:  n_state = CV_IDLE;
            endcase
        end
    end

    always_comb begin
        o_sts.done  = (r_state == CV_DONE);
        o_sts.nd    = r_nd;
        o_top_digit = r_dig[NDIG-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mag  <= i_mag;
            r_base <= i_radix;
            r_bit  <= '1;
            r_nd   <= CNT_W'(1);
            for (int i = 0; i < NDIG; i++) begin
                r_dig[i] <= '0;
            end
        end else begin
            case (r_state)
                CV_RUN: begin
                    r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
                    r_bit <= r_bit - BIT_W'(1);
                    r_nd  <= w_nd_new;
                    r_rem <= CNT_W'(NDIG) - w_nd_new;
                    for (int i = 0; i < NDIG; i++) begin
                        r_dig[i] <= w_next[i];
                    end
                end
                CV_ALIGN: begin
                    if (r_rem >= CNT_W'(ALIGN_STEP)) begin
                        r_rem <= r_rem - CNT_W'(ALIGN_STEP);
                        for (int i = ALIGN_STEP; i < NDIG; i++) begin
                            r_dig[i] <= r_dig[i-ALIGN_STEP];
                        end
                        for (int i = 0; i < ALIGN_STEP; i++) begin
                            r_dig[i] <= '0;
                        end
                    end else if (r_rem != '0) begin
                        r_rem <= r_rem - CNT_W'(1);
                        for (int i = 1; i < NDIG; i++) begin
                            r_dig[i] <= r_dig[i-1];
                        end
                        r_dig[0] <= '0;
                    end
                end
                CV_DONE: begin
                    if (i_ctl.pop) begin
                        for (int i = 1; i < NDIG; i++) begin
                            r_dig[i] <= r_dig[i-1];
                        end
                        r_dig[0] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/core/itaf_emit.sv
// Back-end sequencer: takes a job from the queue, runs the converter and
// walks the layout segments, one character per transaction.
// Depends on itaf_pkg and itaf_if.
module itaf_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  itaf_pkg::t_job             i_job,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    output itaf_pkg::t_conv_ctl        o_conv_ctl,
    input  itaf_pkg::t_conv_sts        i_conv_sts,
    input  logic [itaf_pkg::DIG_W-1:0] i_top_digit,
    itaf_out_if.source                 o_out
);
    import itaf_pkg::*;

    t_emit_state         r_state;
    t_emit_state         n_state;
    t_job                r_job;
    logic [CNT_W-1:0]    r_seg_cnt;
    logic [CNT_W-1:0]    r_emit_cnt;
    logic                r_ov;
    logic [CHAR_W-1:0]   r_ch;
    logic                r_last;
    logic [STATUS_W-1:0] r_status;

    logic [CNT_W-1:0]    w_prec_eff;
    logic [CNT_W-1:0]    w_body;
    logic [CNT_W-1:0]    w_fw;
    logic [CNT_W-1:0]    w_pad;
    logic [CNT_W-1:0]    w_total;
    logic                w_trunc;
    logic [CNT_W-1:0]    w_count;
    logic                w_last;
    logic                w_slot;
    logic                w_in_seg;
    logic                w_fire;
    logic [CNT_W-1:0]    w_len_next;
    logic [CHAR_W-1:0]   w_ch;

    // Line layout sizes; the digit count is stable once the converter is done.
    always_comb begin
        w_prec_eff = (i_conv_sts.nd > CNT_W'(r_job.prec)) ? i_conv_sts.nd : CNT_W'(r_job.prec);
        w_body     = CNT_W'(r_job.pre_len) + CNT_W'(r_job.has_sign) + w_prec_eff;
        w_fw       = CNT_W'(r_job.fw);
        w_pad      = (w_fw > w_body) ? w_fw - w_body : '0;
        w_total    = w_pad + w_body;
        w_trunc    = (w_total > CNT_W'(MAX_CHARS));
        w_count    = w_trunc ? CNT_W'(MAX_CHARS) : w_total;
        w_last     = (r_emit_cnt == w_count - CNT_W'(1));
    end

    assign w_slot   = !r_ov || o_out.ready;
    assign w_in_seg = (r_state == EM_PREFIX) || (r_state == EM_LSPACE) ||
                      (r_state == EM_SIGN)   || (r_state == EM_ZFILL)  ||
                      (r_state == EM_PZERO)  || (r_state == EM_DIGIT)  ||
                      (r_state == EM_TSPACE);
    assign w_fire   = w_slot && ((w_in_seg && (r_seg_cnt != '0)) || (r_state == EM_ERROR));

    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job.err ? EM_ERROR : EM_WAIT;
                end
            end
            EM_WAIT: begin
                if (i_conv_sts.done) begin
                    n_state = EM_PREFIX;
                end
            end
            EM_ERROR: begin
                if (w_fire) begin
                    n_state = EM_IDLE;
                end
            end
            EM_PREFIX, EM_LSPACE, EM_SIGN, EM_ZFILL, EM_PZERO, EM_DIGIT, EM_TSPACE: begin
                if (r_seg_cnt == '0) begin
                    case (r_state)
                        EM_PREFIX: n_state = EM_LSPACE;
                        EM_LSPACE: n_state = EM_SIGN;
                        EM_SIGN:   n_state = EM_ZFILL;
                        EM_ZFILL:  n_state = EM_PZERO;
                        EM_PZERO:  n_state = EM_DIGIT;
                        EM_DIGIT:  n_state = EM_TSPACE;
                        default:   n_state = EM_IDLE;
                    endcase
                end else if (w_fire && w_last) begin
                    n_state = EM_IDLE;
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop          = (r_state == EM_IDLE) && !i_q_empty;
        o_conv_ctl.start = o_q_pop && !i_job.err;
        o_conv_ctl.pop   = w_fire && (r_state == EM_DIGIT);

        case (n_state)
            EM_PREFIX: w_len_next = CNT_W'(r_job.pre_len);
            EM_LSPACE: w_len_next = (!r_job.left && !r_job.zero) ? w_pad : '0;
            EM_SIGN:   w_len_next = CNT_W'(r_job.has_sign);
            EM_ZFILL:  w_len_next = r_job.zero ? w_pad : '0;
            EM_PZERO:  w_len_next = w_prec_eff - i_conv_sts.nd;
            EM_DIGIT:  w_len_next = i_conv_sts.nd;
            EM_TSPACE: w_len_next = r_job.left ? w_pad : '0;
            default:   w_len_next = '0;
        endcase

        case (r_state)
            EM_PREFIX: begin
                // Hex prefix: '0' then 'x'.
                if ((r_job.pre_len == PRE_LEN_HEX) && (r_seg_cnt == CNT_W'(1))) begin
                    w_ch = CH_X;
                end else begin
                    w_ch = CH_ZERO;
                end
            end
            EM_SIGN:   w_ch = r_job.minus ? CH_MINUS : CH_SPACE;
            EM_ZFILL:  w_ch = CH_ZERO;
            EM_PZERO:  w_ch = CH_ZERO;
            EM_DIGIT:  w_ch = digit_char(i_top_digit);
            EM_LSPACE: w_ch = CH_SPACE;
            EM_TSPACE: w_ch = CH_SPACE;
            default:   w_ch = CH_NUL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job      <= i_job;
            r_emit_cnt <= '0;
        end else if (w_fire) begin
            r_emit_cnt <= r_emit_cnt + CNT_W'(1);
        end
        if (n_state != r_state) begin
            r_seg_cnt <= w_len_next;
        end else if (w_fire) begin
            r_seg_cnt <= r_seg_cnt - CNT_W'(1);
        end
        if (w_fire) begin
            r_ch <= w_ch;
            if (r_state == EM_ERROR) begin
                r_last   <= 1'b1;
                r_status <= ST_BADBASE;
            end else begin
                r_last   <= w_last;
                r_status <= w_trunc ? ST_TRUNC : ST_OK;
            end
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.ch     = r_ch;
    assign o_out.last   = r_last;
    assign o_out.status = r_status;

endmodule

>>> rtl/core/integer_to_ascii_formatter_top.sv
// Integer-to-ASCII formatter. A request's first character follows its conversion,
// which steps through the magnitude bits in the bit-serial digit cells, then the
// alignment shifts and any empty layout segments ahead of it. The back end formats
// one request at a time and starts the next only once the last character of the
// previous one is issued; an invalid base yields a single transaction. The queue
// holds two requests. Reset clears the control state and the queue; no clearing pass.
module integer_to_ascii_formatter_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    itaf_in_if.sink  i_in,
    itaf_out_if.source o_out
);
    import itaf_pkg::*;

    logic                w_push;
    logic                w_full;
    logic                w_pop;
    logic                w_q_empty;
    t_job                w_job_in;
    t_job                w_job_head;
    t_conv_ctl           w_conv_ctl;
    t_conv_sts           w_conv_sts;
    logic [DIG_W-1:0]    w_top_digit;

    itaf_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_job_in)
    );

    itaf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_dout  (w_job_head),
        .o_empty (w_q_empty)
    );

    itaf_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_conv_ctl),
        .i_mag       (w_job_head.mag),
        .i_radix     (w_job_head.radix),
        .o_sts       (w_conv_sts),
        .o_top_digit (w_top_digit)
    );

    itaf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_head),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_pop),
        .o_conv_ctl  (w_conv_ctl),
        .i_conv_sts  (w_conv_sts),
        .i_top_digit (w_top_digit),
        .o_out       (o_out)
    );

    // Digits are taken only from a finished conversion.
    a_pop_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_ctl.pop |-> w_conv_sts.done)
        else $error("digit taken before conversion finished");

    // A new conversion never reports done in the cycle after its start.
    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_ctl.start |=> !w_conv_sts.done)
        else $error("converter done right after start");

    // An invalid base produces a single, final transaction.
    a_badbase_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_BADBASE)) |-> o_out.last)
        else $error("invalid base result not marked last");

endmodule

>>> verif/integer_to_ascii_formatter_top_tb.sv
// Self-checking testbench for integer_to_ascii_formatter_top: directed and random
// formatting requests, checked character by character against an in-bench predictor.
// Depends on itaf_pkg and the itaf_in_if / itaf_out_if interfaces from the RTL.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_top_tb;
    import itaf_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int PAUSE_EVERY = 39;

    localparam logic [FLAG_W-1:0] F_ZERO   = FLAG_W'(1) << FL_ZERO;
    localparam logic [FLAG_W-1:0] F_LEFT   = FLAG_W'(1) << FL_LEFT;
    localparam logic [FLAG_W-1:0] F_SPACE  = FLAG_W'(1) << FL_SPACE;
    localparam logic [FLAG_W-1:0] F_SIGNED = FLAG_W'(1) << FL_SIGNED;
    localparam logic [FLAG_W-1:0] F_PREFIX = FLAG_W'(1) << FL_PREFIX;

    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [WIDTH_W-1:0] fw;
        logic [WIDTH_W-1:0] prec;
        logic [FLAG_W-1:0]  flags;
    } t_fmt_req;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_fmt_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itaf_in_if  in_if ();
    itaf_out_if out_if ();

    integer_to_ascii_formatter_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_fmt_req  request_queue [$];
    t_fmt_char expected_chars [$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left = 0;
    logic in_fire = 1'b0;
    int   idle_cycles = 0;

    int error_count = 0;
    int requests_taken = 0;
    int chars_checked = 0;
    int trunc_seen = 0;
    int badbase_seen = 0;

    // Builds the printf-style text for one request and queues its characters.
    function automatic void format_request(input t_fmt_req r);
        logic [VALUE_W-1:0]  mag;
        logic [FLAG_W-1:0]   fl;
        logic [CHAR_W-1:0]   text [$];
        logic [CHAR_W-1:0]   digs [$];
        logic [CHAR_W-1:0]   sign_ch;
        logic                has_sign;
        logic [STATUS_W-1:0] st;
        t_fmt_char           c;
        int                  w;
        int                  p;
        int                  padn;
        int                  count;
        mag = r.value;
        fl = r.flags;
        w = int'(r.fw);
        p = int'(r.prec);
        has_sign = 1'b0;
        sign_ch = CH_SPACE;
        if (fl[FL_LEFT]) begin
            fl[FL_ZERO] = 1'b0;
        end
        if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
            c.ch = CH_NUL;
            c.last = 1'b1;
            c.status = ST_BADBASE;
            expected_chars.push_back(c);
            return;
        end
        if (fl[FL_SIGNED]) begin
            if (mag[VALUE_W-1]) begin
                has_sign = 1'b1;
                sign_ch = CH_MINUS;
                mag = ~mag + VALUE_W'(1);
                w--;
            end else if (fl[FL_SPACE]) begin
                has_sign = 1'b1;
                w--;
            end
        end
        if (fl[FL_PREFIX] && r.radix == RADIX_HEX) begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
            w -= 2;
        end else if (fl[FL_PREFIX] && r.radix == RADIX_OCT) begin
            text.push_back(CH_ZERO);
            w--;
        end
        // Digits are collected least significant first; zero still yields one digit.
        do begin
            digs.push_back(DIGIT_SET[int'(mag % r.radix)]);
            mag = mag / r.radix;
        end while (mag != 0);
        if (digs.size() > p) begin
            p = digs.size();
        end
        w -= p;
        padn = (w > 0) ? w : 0;
        if (!fl[FL_LEFT] && !fl[FL_ZERO]) begin
            repeat (padn) text.push_back(CH_SPACE);
        end
        if (has_sign) begin
            text.push_back(sign_ch);
        end
        if (!fl[FL_LEFT] && fl[FL_ZERO]) begin
            repeat (padn) text.push_back(CH_ZERO);
        end
        repeat (p - digs.size()) text.push_back(CH_ZERO);
        while (digs.size() > 0) begin
            text.push_back(digs.pop_back());
        end
        if (fl[FL_LEFT]) begin
            repeat (padn) text.push_back(CH_SPACE);
        end
        count = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
        st = (text.size() > MAX_CHARS) ? ST_TRUNC : ST_OK;
        for (int k = 0; k < count; k++) begin
            c.ch = text[k];
            c.last = (k == count - 1);
            c.status = st;
            expected_chars.push_back(c);
        end
    endfunction

    task automatic add_req(input logic [VALUE_W-1:0] v, input int rad, input int fw,
                           input int prec, input logic [FLAG_W-1:0] fl);
        t_fmt_req r;
        r.value = v;
        r.radix = RADIX_W'(rad);
        r.fw = WIDTH_W'(fw);
        r.prec = WIDTH_W'(prec);
        r.flags = fl;
        request_queue.push_back(r);
    endtask

    // Returns on a rising edge once everything offered has been taken and answered.
    task automatic wait_drain();
        while (request_queue.size() != 0 || in_if.valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int send_pct, input int stall_pct,
                             input bit with_hold);
        logic [VALUE_W-1:0] v;
        int                 rad;
        int                 fw;
        int                 prec;
        int                 pick;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(7))
                0: v = VALUE_W'($urandom_range(0, 1000));
                1: v = {$urandom, $urandom};
                2: v = -VALUE_W'($urandom_range(1, 1000));
                3: begin
                    pick = $urandom_range(4);
                    v = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES :
                        (pick == 2) ? MOST_NEG : (pick == 3) ? MOST_POS : VALUE_W'(1);
                end
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            pick = $urandom_range(19);
            if (pick < 2) begin
                rad = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(37, 63);
            end else if (pick < 5) begin
                rad = int'(RADIX_HEX);
            end else if (pick < 7) begin
                rad = int'(RADIX_OCT);
            end else if (pick < 9) begin
                rad = 10;
            end else if (pick == 9) begin
                rad = int'(RADIX_MIN);
            end else begin
                rad = $urandom_range(RADIX_MIN, RADIX_MAX);
            end
            fw = ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
            prec = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
            add_req(v, rad, fw, prec, FLAG_W'($urandom_range(0, 31)));
            if (with_hold && i == 0) begin
                holds_asked++;
            end
            // The sender goes quiet now and then until the block has answered everything.
            if (i % PAUSE_EVERY == PAUSE_EVERY - 1) begin
                wait_drain();
            end
        end
        wait_drain();
    endtask

    // Driver: a new transaction is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        t_fmt_req nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = request_queue.pop_front();
                in_if.value <= nxt.value;
                in_if.radix <= nxt.radix;
                in_if.field_width <= nxt.fw;
                in_if.min_digits <= nxt.prec;
                in_if.flag_bits <= nxt.flags;
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs counted here on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            out_if.ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted character.
    always @(posedge i_clk) begin
        t_fmt_req  req;
        t_fmt_char got;
        t_fmt_char want;
        in_fire <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                req.value = in_if.value;
                req.radix = in_if.radix;
                req.fw = in_if.field_width;
                req.prec = in_if.min_digits;
                req.flags = in_if.flag_bits;
                format_request(req);
                requests_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got.ch = out_if.ch;
                got.last = out_if.last;
                got.status = out_if.status;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h/%b/%0d",
                             $time, got.ch, got.last, got.status);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (got.ch !== want.ch) begin
                        $display("%0t: ch mismatch: expected %h, actual %h",
                                 $time, want.ch, got.ch);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, got.last);
                        error_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (want.last && want.status == ST_TRUNC) begin
                        trunc_seen++;
                    end
                    if (want.status == ST_BADBASE) begin
                        badbase_seen++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        in_if.radix = '0;
        in_if.field_width = '0;
        in_if.min_digits = '0;
        in_if.flag_bits = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, every flag and each corner of the layout.
        add_req('0, 10, 0, 0, '0);
        add_req(ALL_ONES, int'(RADIX_MIN), 0, 0, '0);
        add_req(MOST_NEG, int'(RADIX_MIN), 0, 0, F_SIGNED);
        add_req(MOST_NEG, 10, 0, 0, F_SIGNED);
        add_req(MOST_POS, 10, 0, 0, F_SIGNED | F_SPACE);
        add_req(ALL_ONES, int'(RADIX_MAX), 63, 0, '0);
        add_req(64'd35, int'(RADIX_MAX), 0, 0, '0);
        add_req(64'd5, 0, 0, 0, '0);
        add_req(64'd5, 1, 10, 3, F_ZERO | F_PREFIX);
        add_req(64'd5, 37, 0, 0, F_LEFT);
        add_req(ALL_ONES, 63, 63, 63, '1);
        add_req(64'd255, int'(RADIX_HEX), 10, 0, F_ZERO | F_PREFIX);
        add_req(64'd8, int'(RADIX_OCT), 8, 0, F_PREFIX);
        add_req(64'd99, 10, 6, 0, F_PREFIX);
        add_req(64'd42, 10, 8, 0, F_LEFT | F_ZERO);
        add_req(64'd5, 10, 4, 0, F_SPACE);
        add_req(64'd5, 10, 6, 0, F_SPACE | F_SIGNED);
        add_req(-64'd77, 10, 8, 0, F_SIGNED | F_ZERO);
        add_req(64'd1, int'(RADIX_HEX), 0, 63, F_PREFIX);
        add_req(-64'd1, 10, 0, 63, F_SIGNED);
        add_req('0, 10, 0, 5, '0);
        add_req(-64'd300, int'(RADIX_HEX), 20, 0, F_LEFT | F_PREFIX | F_SIGNED);
        add_req(MOST_NEG, int'(RADIX_HEX), 63, 63, '1);
        add_req('0, int'(RADIX_HEX), 0, 0, F_PREFIX);
        add_req(64'd6, int'(RADIX_MIN), 63, 0, F_LEFT);
        wait_drain();

        run_phase(78, 0, 0, 1'b0);
        run_phase(78, 50, 0, 1'b0);
        run_phase(78, 0, 50, 1'b1);
        run_phase(78, 18, 18, 1'b0);
        run_phase(78, 0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Formatted %0d requests into %0d checked characters.",
                 requests_taken, chars_checked);
        $display("Truncated outputs: %0d, bad-base errors: %0d, mismatches: %0d.",
                 trunc_seen, badbase_seen, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> integer_to_ascii_formatter_top.f
rtl/core/itaf_pkg.sv
rtl/core/itaf_if.sv
rtl/core/itaf_front.sv
rtl/core/itaf_fifo.sv
rtl/core/itaf_conv.sv
rtl/core/itaf_emit.sv
rtl/core/integer_to_ascii_formatter_top.sv
verif/integer_to_ascii_formatter_top_tb.sv
